>>> sv/abm_pkg.sv
// Package with the shared types and constants of the adjacency bit matrix.
`timescale 1ns / 1ps

package abm_pkg;

  localparam int MAX_VERTICES  = 256;
  localparam int WORD_BITS     = 64;
  localparam int WORDS_PER_ROW = (MAX_VERTICES + WORD_BITS - 1) / WORD_BITS;
  localparam int MEM_DEPTH     = MAX_VERTICES * WORDS_PER_ROW;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);
  localparam int WORD_W        = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
  localparam int CNT_W         = $clog2(WORDS_PER_ROW + 1);
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int POP_W         = $clog2(WORD_BITS + 1);
  localparam int NODE_W        = 8;
  localparam int LIM_W         = 9;
  localparam int CMD_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DEGREE = 2'd2
  } abm_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } abm_in_t;

  typedef struct packed {
    logic             linked;
    logic [LIM_W-1:0] degree;
    logic             range_error;
  } abm_out_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } abm_mem_req_t;

endpackage

>>> sv/adjacency_bit_matrix_top.sv
// Top level of the undirected adjacency bit matrix with its vertex count register.
// An accepted command runs a start step, then its own steps (two read-modify-writes for an
// add, one read for a query, one step per row word for a degree), then a done step that
// registers the result; a rejected or undefined command goes from start straight to done.
// One item is in work at a time. A finished result may wait while the next item runs.
// After reset the matrix is cleared one word a cycle, all 1024 words, and no item is taken meanwhile.
`timescale 1ns / 1ps

module adjacency_bit_matrix_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [abm_pkg::LIM_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  input  abm_pkg::abm_in_t            in_item_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  output abm_pkg::abm_out_t           out_item_o,
  input  logic                        out_stall_i
);

  logic [abm_pkg::LIM_W-1:0]     vcount_q;
  logic [abm_pkg::LIM_W-1:0]     lim;
  abm_pkg::abm_mem_req_t         mem_req;
  logic [abm_pkg::WORD_BITS-1:0] mem_rdata;
  logic [abm_pkg::WORD_BITS-1:0] pop_word;
  logic [abm_pkg::POP_W-1:0]     pop_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 9'd256;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // A count above the matrix size acts as the matrix size.
  assign lim = (32'(vcount_q) > 32'(abm_pkg::MAX_VERTICES))
             ? abm_pkg::LIM_W'(abm_pkg::MAX_VERTICES) : vcount_q;

  abm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .pop_word_o  (pop_word),
    .pop_count_i (pop_count)
  );

  abm_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  abm_popcnt u_popcnt (
    .word_i  (pop_word),
    .count_o (pop_count)
  );

endmodule

>>> sv/abm_mem.sv
// Matrix storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module abm_mem (
  input  logic                           clk_i,
  input  abm_pkg::abm_mem_req_t          req_i,
  output logic [abm_pkg::WORD_BITS-1:0]  rdata_o
);

  logic [abm_pkg::WORD_BITS-1:0] mem_q [abm_pkg::MEM_DEPTH];
  logic [abm_pkg::WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read returns the old contents when the same word is written in that cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/abm_popcnt.sv
// Shared population count unit for one 64-bit row word.
`timescale 1ns / 1ps

module abm_popcnt (
  input  logic [abm_pkg::WORD_BITS-1:0] word_i,
  output logic [abm_pkg::POP_W-1:0]     count_o
);

  logic [63:0] x1, x2, x3, x4, x5, x6;

  always_comb begin
    x1 = word_i - ((word_i >> 1) & 64'h5555_5555_5555_5555);
    x2 = (x1 & 64'h3333_3333_3333_3333) + ((x1 >> 2) & 64'h3333_3333_3333_3333);
    x3 = (x2 + (x2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    x4 = x3 + (x3 >> 8);
    x5 = x4 + (x4 >> 16);
    x6 = x5 + (x5 >> 32);
  end

  assign count_o = x6[abm_pkg::POP_W-1:0];

endmodule

>>> sv/abm_seq.sv
// Command sequencer: clearing pass, read-modify-write, query and degree steps.
`timescale 1ns / 1ps

module abm_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [abm_pkg::LIM_W-1:0]      lim_i,
  input  logic                           in_valid_i,
  input  abm_pkg::abm_in_t               in_item_i,
  output logic                           in_stall_o,
  output logic                           out_valid_o,
  output abm_pkg::abm_out_t              out_item_o,
  input  logic                           out_stall_i,
  output abm_pkg::abm_mem_req_t          mem_req_o,
  input  logic [abm_pkg::WORD_BITS-1:0]  mem_rdata_i,
  output logic [abm_pkg::WORD_BITS-1:0]  pop_word_o,
  input  logic [abm_pkg::POP_W-1:0]      pop_count_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_ADD2  = 3'd3;
  localparam logic [2:0] ST_ADD3  = 3'd4;
  localparam logic [2:0] ST_QRY   = 3'd5;
  localparam logic [2:0] ST_DEG   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [abm_pkg::ADDR_W-1:0]     clr_q, clr_d;
  logic [abm_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  abm_pkg::abm_in_t               item_q, item_d;
  logic                           linked_q, linked_d;
  logic [abm_pkg::LIM_W-1:0]      deg_q, deg_d;
  logic                           err_q, err_d;
  logic                           out_valid_q, out_valid_d;
  abm_pkg::abm_out_t              out_q, out_d;
  logic                           err_a, err_b, cmd_err;
  logic [abm_pkg::WORD_W-1:0]     rx_word;
  logic [abm_pkg::WORD_BITS-1:0]  col_mask;
  logic [31:0]                    col;

  function automatic logic [abm_pkg::ADDR_W-1:0] word_addr(
    input logic [abm_pkg::NODE_W-1:0] row,
    input logic [abm_pkg::WORD_W-1:0] word
  );
    logic [31:0] lin;
    lin = 32'(row) * 32'(abm_pkg::WORDS_PER_ROW) + 32'(word);
    return lin[abm_pkg::ADDR_W-1:0];
  endfunction

  // Word of a row that holds the given column.
  function automatic logic [abm_pkg::WORD_W-1:0] col_word(
    input logic [abm_pkg::NODE_W-1:0] node
  );
    logic [abm_pkg::NODE_W-1:0] sh;
    sh = node >> abm_pkg::BIT_W;
    return sh[abm_pkg::WORD_W-1:0];
  endfunction

  assign err_a   = {1'b0, item_q.node_a} >= lim_i;
  assign err_b   = {1'b0, item_q.node_b} >= lim_i;
  assign cmd_err = (item_q.cmd == abm_pkg::CMD_DEGREE) ? err_a
                 : ((item_q.cmd == abm_pkg::CMD_ADD) || (item_q.cmd == abm_pkg::CMD_QUERY))
                   ? (err_a || err_b) : 1'b0;

  // Degree only counts columns below the current vertex limit.
  assign rx_word = abm_pkg::WORD_W'(cnt_q - abm_pkg::CNT_W'(1));
  always_comb begin
    col      = '0;
    col_mask = '0;
    for (int j = 0; j < abm_pkg::WORD_BITS; j++) begin
      col         = 32'(rx_word) * 32'(abm_pkg::WORD_BITS) + 32'(j);
      col_mask[j] = col < 32'(lim_i);
    end
  end
  assign pop_word_o = mem_rdata_i & col_mask;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    linked_d    = linked_q;
    deg_d       = deg_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_req_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        clr_d           = clr_q + abm_pkg::ADDR_W'(1);
        if (clr_q == abm_pkg::ADDR_W'(abm_pkg::MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_START;
        end
      end
      ST_START: begin
        linked_d = 1'b0;
        deg_d    = '0;
        err_d    = cmd_err;
        if (cmd_err) begin
          state_d = ST_DONE;
        end else begin
          case (item_q.cmd)
            abm_pkg::CMD_ADD: begin
              mem_req_o.raddr = word_addr(item_q.node_a, col_word(item_q.node_b));
              state_d         = ST_ADD2;
            end
            abm_pkg::CMD_QUERY: begin
              mem_req_o.raddr = word_addr(item_q.node_a, col_word(item_q.node_b));
              state_d         = ST_QRY;
            end
            abm_pkg::CMD_DEGREE: begin
              mem_req_o.raddr = word_addr(item_q.node_a, '0);
              cnt_d           = abm_pkg::CNT_W'(1);
              state_d         = ST_DEG;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_ADD2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = word_addr(item_q.node_a, col_word(item_q.node_b));
        mem_req_o.wdata = mem_rdata_i
                        | (abm_pkg::WORD_BITS'(1) << item_q.node_b[abm_pkg::BIT_W-1:0]);
        // For a self link the second word is the first and carries the same bit.
        mem_req_o.raddr = word_addr(item_q.node_b, col_word(item_q.node_a));
        state_d         = ST_ADD3;
      end
      ST_ADD3: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = word_addr(item_q.node_b, col_word(item_q.node_a));
        mem_req_o.wdata = mem_rdata_i
                        | (abm_pkg::WORD_BITS'(1) << item_q.node_a[abm_pkg::BIT_W-1:0]);
        state_d         = ST_DONE;
      end
      ST_QRY: begin
        linked_d = mem_rdata_i[item_q.node_b[abm_pkg::BIT_W-1:0]];
        state_d  = ST_DONE;
      end
      ST_DEG: begin
        deg_d = deg_q + abm_pkg::LIM_W'(pop_count_i);
        if (cnt_q == abm_pkg::CNT_W'(abm_pkg::WORDS_PER_ROW)) begin
          state_d = ST_DONE;
        end else begin
          mem_req_o.raddr = word_addr(item_q.node_a, cnt_q[abm_pkg::WORD_W-1:0]);
          cnt_d           = cnt_q + abm_pkg::CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.linked      = linked_q;
          out_d.degree      = deg_q;
          out_d.range_error = err_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    linked_q <= linked_d;
    deg_q    <= deg_d;
    err_q    <= err_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside the done step");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_QRY) |-> !mem_req_o.we)
    else $error("matrix written outside an add or clearing step");

  a_deg_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEG && cnt_q == abm_pkg::CNT_W'(abm_pkg::WORDS_PER_ROW))
    |=> state_q == ST_DONE)
    else $error("degree count did not finish after the last row word");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.range_error) |-> (!out_q.linked && out_q.degree == '0))
    else $error("rejected command reported a nonzero result");
`endif

endmodule
